[rtl/core/npt_pkg.sv]
// npt_pkg: shared types for the next-prime trial-division core.
// No dependencies.
package npt_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_TEST,
        S_DIV,
        S_OUT
    } npt_state_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } npt_rem_status_t;

endpackage

[rtl/core/next_prime_trial_division_core.sv]
// next_prime_trial_division_core: smallest prime >= start_value by trial division.
// Each candidate is tested with up to about sqrt(v)/2 odd trial divisors in the shared
// remainder unit, one candidate after another across the prime gap.
// Throughput: one word at a time; in_ready is high only while idle.
// Reset (rst_n, async low) returns the sequencer to idle and drops out_valid.
// Depends on npt_pkg and npt_rem_unit.
module next_prime_trial_division_core
    import npt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [VALUE_WIDTH-1:0] start_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VALUE_WIDTH:0] next_prime,
    output logic                 start_was_prime
);

    localparam int CW = VALUE_WIDTH + 1;
    localparam int DW = VALUE_WIDTH / 2 + 2;
    localparam int SW = VALUE_WIDTH + 3;

    npt_state_t      state_reg, state_next;
    logic [CW-1:0]   cand_reg, cand_next;
    logic [DW-1:0]   d_reg, d_next;
    logic [SW-1:0]   sq_reg, sq_next;
    logic            first_reg, first_next;
    logic            was_prime_reg, was_prime_next;
    logic            div_start;
    npt_rem_status_t rem_status;

    npt_rem_unit #(
        .CW (CW),
        .DW (DW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cand_reg),
        .divisor  (d_reg),
        .status   (rem_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        first_reg     <= first_next;
        was_prime_reg <= was_prime_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        first_next     = first_reg;
        was_prime_next = was_prime_reg;
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cand_next  = {1'b0, start_value};
                    first_next = 1'b1;
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                d_next  = DW'(3);
                sq_next = SW'(9);
                if (cand_reg == CW'(2))
                begin
                    was_prime_next = first_reg;
                    state_next     = S_OUT;
                end
                else if (cand_reg < CW'(2) || !cand_reg[0])
                begin
                    // even or below two: move to next candidate
                    first_next = 1'b0;
                    cand_next  = cand_reg + CW'(1);
                end
                else
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (sq_reg > SW'(cand_reg))
                begin
                    was_prime_next = first_reg;
                    state_next     = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_status.done)
                begin
                    if (rem_status.rem_zero)
                    begin
                        first_next = 1'b0;
                        cand_next  = cand_reg + CW'(1);
                        state_next = S_CAND;
                    end
                    else
                    begin
                        // (d+2)^2 = d^2 + 4d + 4
                        d_next     = d_reg + DW'(2);
                        sq_next    = sq_reg + SW'({d_reg, 2'b00}) + SW'(4);
                        state_next = S_TEST;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = (state_reg == S_OUT);
    assign next_prime      = cand_reg;
    assign start_was_prime = was_prime_reg;

    a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST || state_reg == S_DIV) |-> (d_reg[0] && d_reg >= DW'(3)))
        else $error("trial divisor not odd or below three");

    a_result_at_least_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> next_prime >= CW'(2))
        else $error("result below two");

    a_prime_flag_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && start_was_prime) |-> first_reg)
        else $error("prime flag set for a later candidate");

endmodule

[rtl/core/npt_rem_unit.sv]
// npt_rem_unit: shift-subtract remainder unit, one dividend bit per cycle.
// Depends on npt_pkg.
module npt_rem_unit
    import npt_pkg::*;
#(
    parameter int CW = 33,
    parameter int DW = 18
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [CW-1:0]   dividend,
    input  logic [DW-1:0]   divisor,
    output npt_rem_status_t status
);

    localparam int CNTW = $clog2(CW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [CW-1:0]   dvd_reg;
    logic [DW-1:0]   dvs_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic [DW-1:0]   rem_next;

    // trial < 2*divisor, so the top bit of diff is the borrow
    always_comb
    begin
        trial = {rem_reg, dvd_reg[CW-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (!diff[DW])
        begin
            rem_next = diff[DW-1:0];
        end
        else
        begin
            rem_next = trial[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(CW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[CW-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < dvs_reg)
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a running division");

endmodule
